// File: rtl/inverse_euler_transform_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inverse Euler transform unit
// Shared helpers for concurrent checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INVERSE_EULER_TRANSFORM_UNIT_DEFINES_SVH
`define INVERSE_EULER_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication
`define IET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iet_pkg.sv
// ----------------------------------------------------------------------------
// iet_pkg
// Widths and controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package iet_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic in_ready;
        logic store_term;
        logic init_t;
        logic sub_d;
        logic conv_issue;
        logic div_start;
        logic scale;
        logic upd_rd;
        logic upd_wr;
        logic out_load;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic over;
        logic idx_zero;
        logic start;
        logic conv_none;
        logic conv_last;
        logic pipe_busy;
        logic div_done;
        logic upd_last;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/iet_in_if.sv
// ----------------------------------------------------------------------------
// iet_in_if
// Input channel: one series coefficient per beat.
// ----------------------------------------------------------------------------
interface iet_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [iet_pkg::WORD_W-1:0]  term;
    logic                               start_req;

    modport source (output valid, output term, output start_req, input ready);
    modport sink   (input valid, input term, input start_req, output ready);
endinterface

// File: rtl/iet_out_if.sv
// ----------------------------------------------------------------------------
// iet_out_if
// Output channel: one exponent per beat.
// ----------------------------------------------------------------------------
interface iet_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [iet_pkg::WORD_W-1:0]  exponent;
    logic                               capacity_exceeded;

    modport source (output valid, output exponent, output capacity_exceeded, input ready);
    modport sink   (input valid, input exponent, input capacity_exceeded, output ready);
endinterface

// File: rtl/iet_divider.sv
// ----------------------------------------------------------------------------
// iet_divider
// Signed 64-bit by unsigned index divide, truncating toward zero.
// Restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iet_divider #(
    parameter int DEN_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [iet_pkg::WORD_W-1:0]  num,
    input  logic [DEN_W-1:0]            den,
    output logic                        done,
    output logic [iet_pkg::WORD_W-1:0]  quot
);
    localparam int CNT_W = $clog2(iet_pkg::WORD_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic [iet_pkg::WORD_W-1:0]  mag_reg, mag_next;
    logic [DEN_W-1:0]            rem_reg, rem_next;
    logic [DEN_W-1:0]            den_reg, den_next;
    logic [DEN_W:0]              trial;
    logic                        fits;

    assign trial = {rem_reg, mag_reg[iet_pkg::WORD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[iet_pkg::WORD_W-1];
            mag_next  = num[iet_pkg::WORD_W-1] ? (~num + 1'b1) : num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            mag_next = {mag_reg[iet_pkg::WORD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(iet_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
endmodule

// File: rtl/iet_datapath.sv
// ----------------------------------------------------------------------------
// iet_datapath
// Term and divisor-sum memories, convolution MAC, divider, output register.
// ----------------------------------------------------------------------------
module iet_datapath #(
    parameter int MAX_TERMS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  iet_pkg::cmd_t   cmd,
    output iet_pkg::sts_t   sts,
    iet_in_if.sink          items,
    iet_out_if.source       results
);
    localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int IDX_W = $clog2(MAX_TERMS + 1);
    localparam int W     = iet_pkg::WORD_W;
    localparam int H     = iet_pkg::HALF_W;
    localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(MAX_TERMS);
    localparam logic [AW-1:0]    LAST_ADR = AW'(MAX_TERMS - 1);

    logic [W-1:0] term_mem [MAX_TERMS];
    logic [W-1:0] dsum_mem [MAX_TERMS];

    logic [IDX_W-1:0] idx_reg;
    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    j_reg;
    logic [IDX_W-1:0] m_reg;
    logic             v1_reg, v2_reg;
    logic             out_valid_reg;
    logic             start_reg;
    logic [W-1:0]     b_reg, t_reg, ia_reg;
    logic [W-1:0]     term_q, dsum_q;
    logic [W-1:0]     p_ll_reg;
    logic [H-1:0]     p_x_reg;
    logic [W-1:0]     exp_reg;
    logic             flag_reg;

    logic             accept;
    logic [IDX_W-1:0] term_rd_idx;
    logic [AW-1:0]    dsum_rd_adr;
    logic             dsum_rd_en;
    logic [IDX_W:0]   m_sum;
    logic             div_done;
    logic [W-1:0]     quot;

    assign accept      = items.valid && cmd.in_ready;
    assign items.ready = cmd.in_ready;

    assign term_rd_idx = idx_reg - IDX_W'(j_reg);
    assign m_sum       = {1'b0, m_reg} + {1'b0, idx_reg};
    assign dsum_rd_en  = cmd.init_t || cmd.conv_issue || cmd.upd_rd;

    always_comb
    begin
        dsum_rd_adr = j_reg;
        if (cmd.init_t)
            dsum_rd_adr = idx_reg[AW-1:0];
        else if (cmd.upd_rd)
            dsum_rd_adr = m_reg[AW-1:0];
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.store_term)
            term_mem[idx_reg[AW-1:0]] <= b_reg;
        if (cmd.conv_issue)
            term_q <= term_mem[term_rd_idx[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            dsum_mem[clr_reg] <= '0;
        else if (cmd.upd_wr)
            dsum_mem[m_reg[AW-1:0]] <= dsum_q + ia_reg;
        if (dsum_rd_en)
            dsum_q <= dsum_mem[dsum_rd_adr];
    end

    iet_divider #(
        .DEN_W (IDX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (t_reg),
        .den   (idx_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            clr_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && items.start_req)
                idx_reg <= '0;
            else if (cmd.out_load && !sts.over)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.clr_step)
                clr_reg <= (clr_reg == LAST_ADR) ? '0 : clr_reg + 1'b1;
            v1_reg <= cmd.conv_issue;
            v2_reg <= v1_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg     <= $unsigned(items.term);
            start_reg <= items.start_req;
        end
        if (cmd.init_t)
            t_reg <= b_reg * W'(idx_reg);
        else if (cmd.sub_d)
            t_reg <= t_reg - dsum_q;
        else if (v2_reg)
            t_reg <= t_reg - (p_ll_reg + {p_x_reg, {H{1'b0}}});
        if (cmd.sub_d)
            j_reg <= AW'(1);
        else if (cmd.conv_issue)
            j_reg <= j_reg + 1'b1;
        // low 64 bits of the product from three 32x32 partial products
        p_ll_reg <= {{H{1'b0}}, dsum_q[H-1:0]} * {{H{1'b0}}, term_q[H-1:0]};
        p_x_reg  <= dsum_q[H-1:0] * term_q[W-1:H] + dsum_q[W-1:H] * term_q[H-1:0];
        if (cmd.scale)
        begin
            ia_reg <= quot * W'(idx_reg);
            m_reg  <= idx_reg;
        end
        else if (cmd.upd_wr)
            m_reg <= m_sum[IDX_W-1:0];
        if (cmd.out_load)
        begin
            exp_reg  <= (sts.over || sts.idx_zero) ? '0 : quot;
            flag_reg <= sts.over;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.exponent          = $signed(exp_reg);
    assign results.capacity_exceeded = flag_reg;

    always_comb
    begin
        sts.over      = idx_reg >= MAX_IDX;
        sts.idx_zero  = idx_reg == '0;
        sts.start     = start_reg;
        sts.conv_none = idx_reg == IDX_W'(1);
        sts.conv_last = IDX_W'(j_reg) == (idx_reg - 1'b1);
        sts.pipe_busy = v1_reg || v2_reg;
        sts.div_done  = div_done;
        sts.upd_last  = m_sum >= (IDX_W + 1)'(MAX_TERMS);
        sts.clr_last  = clr_reg == LAST_ADR;
        sts.out_free  = !out_valid_reg || results.ready;
    end
endmodule

// File: rtl/iet_ctrl.sv
// ----------------------------------------------------------------------------
// iet_ctrl
// Sequencer: clear sweep, convolution, divide, divisor-sum update, output.
// ----------------------------------------------------------------------------
`include "inverse_euler_transform_unit_defines.svh"

module iet_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  iet_pkg::sts_t   sts,
    output iet_pkg::cmd_t   cmd
);
    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_DECIDE = 11'b000_0000_0100,
        S_SUBD   = 11'b000_0000_1000,
        S_CONV   = 11'b000_0001_0000,
        S_DRAIN  = 11'b000_0010_0000,
        S_DIV    = 11'b000_0100_0000,
        S_SCALE  = 11'b000_1000_0000,
        S_UPD_RD = 11'b001_0000_0000,
        S_UPD_WR = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.store_term = !sts.over;
                if (sts.over || sts.idx_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.init_t = 1'b1;
                    state_next = S_SUBD;
                end
            end
            S_SUBD:
            begin
                cmd.sub_d  = 1'b1;
                state_next = sts.conv_none ? S_DRAIN : S_CONV;
            end
            S_CONV:
            begin
                cmd.conv_issue = 1'b1;
                if (sts.conv_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = sts.upd_last ? S_DONE : S_UPD_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.start ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    `IET_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "output overwritten")
    `IET_ASSERT_NOW(a_idle_quiet, cmd.in_ready, !sts.pipe_busy, "accept while MAC busy")
    `IET_ASSERT_NEXT(a_div_multi, cmd.div_start, !sts.div_done, "divider done too early")
endmodule

// File: rtl/inverse_euler_transform_unit.sv
// ----------------------------------------------------------------------------
// inverse_euler_transform_unit
// Streams series coefficients b_i in, exponents a_i of the Euler product out.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload                      | handshake
//  ---------+-----+-----------------------------------+-----------
//  items    | in  | term (s64), start_req             | valid/ready
//  results  | out | exponent (s64), capacity_exceeded | valid/ready
//
//  One item at a time. Index i (1 <= i < MAX_TERMS) runs a convolution
//  (one stored product per cycle through the memory read ports and a
//  two-stage 64-bit MAC), then the bit-serial divider, then a read and a
//  write per multiple of i for the divisor-sum update. Index 0 and
//  over-capacity items skip the convolution, divide and update.
//  After reset and after every start item the divisor-sum memory is swept
//  to zero, with items held off.
//  A result that is not taken holds the next item in its final state.
// ----------------------------------------------------------------------------
module inverse_euler_transform_unit #(
    parameter int MAX_TERMS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    iet_in_if.sink      items,
    iet_out_if.source   results
);
    iet_pkg::cmd_t cmd;
    iet_pkg::sts_t sts;

    // sequencer
    iet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, MAC, divider and output register
    iet_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .items   (items),
        .results (results)
    );
endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse Euler transform unit. Coefficient
// sequences stream in through the item channel. A bit-accurate predictor
// computes each exponent, and every result beat is checked in order.
// Both channels idle at random. The result side also holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W    = iet_pkg::WORD_W;
    localparam int DEPTH     = 128;
    localparam int RAND_BEATS = 1250;

    typedef struct {
        logic [WORD_W-1:0] exponent;
        logic              capacity_exceeded;
    } exp_beat_t;

    // directed row: typed expectation only where obvious
    typedef struct {
        logic [WORD_W-1:0] term;
        logic              start_req;
        logic              typed;
        logic [WORD_W-1:0] exponent;
        logic              capacity_exceeded;
    } dir_row_t;

    logic clk;
    logic rst_n;

    iet_in_if  item_ch ();
    iet_out_if res_ch ();

    inverse_euler_transform_unit #(.MAX_TERMS(DEPTH)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (res_ch)
    );

    // predictor state: stored coefficients, divisor sums, next index
    logic [WORD_W-1:0] coef_mem [DEPTH];
    logic [WORD_W-1:0] dsum_mem [DEPTH];
    int unsigned       next_idx;

    exp_beat_t exp_q [$];
    int        fail_cnt;
    int        sent_cnt;
    bit        quiet;      // no idling on either side while set
    int        hold_cycles;
    bit        hold_done;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // every input known from time zero; reset released on a falling clock edge
    initial begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.term      = '0;
        item_ch.start_req = 1'b0;
        res_ch.ready      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Compute the exponent for one accepted coefficient. Arithmetic wraps
    // at 64 bits; the divide truncates toward zero like C.
    function automatic exp_beat_t exponent_of(logic [WORD_W-1:0] b, logic start);
        exp_beat_t         r;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] a;
        longint            quo;
        int unsigned       i;

        if (start)
        begin
            foreach (dsum_mem[k]) dsum_mem[k] = '0;
            next_idx = 0;
        end
        if (next_idx >= DEPTH)
        begin
            // past capacity: nothing stored, index parks
            next_idx = DEPTH;
            r.exponent = '0;
            r.capacity_exceeded = 1'b1;
            return r;
        end
        i = next_idx;
        coef_mem[i] = b;
        r.capacity_exceeded = 1'b0;
        if (i == 0)
        begin
            // leading coefficient is taken as 1, exponent always 0
            next_idx = 1;
            r.exponent = '0;
            return r;
        end
        acc = WORD_W'(i) * b;
        acc = acc - dsum_mem[i];         // proper-divisor part so far
        for (int j = 1; j < i; j++)
            acc = acc - dsum_mem[j] * coef_mem[i - j];
        quo = $signed(acc) / longint'(i);
        a = quo;
        // fold i*a_i into every multiple of i
        for (int m = i; m < DEPTH; m += i)
            dsum_mem[m] = dsum_mem[m] + WORD_W'(i) * a;
        next_idx = i + 1;
        r.exponent = a;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        fail_cnt++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    // Drive one coefficient beat and wait for it to be taken. Idle gaps
    // (valid low) are inserted first, at random unless in a quiet stretch.
    task automatic send_beat(logic [WORD_W-1:0] b, logic start, bit typed,
                             exp_beat_t typed_exp);
        exp_beat_t pred;

        while (!quiet && $urandom_range(99) < 34)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.term      <= b;
        item_ch.start_req <= start;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        pred = exponent_of(b, start);
        exp_q.insert(exp_q.size(), typed ? typed_exp : pred);
        sent_cnt++;
        @(negedge clk);
    endtask

    // Result side: random backpressure plus one long hold-off once the
    // stream is well under way, so the unit backs up and stalls its input.
    initial begin
        hold_cycles = 0;
        hold_done   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_cnt >= 300)
            begin
                hold_done   = 1'b1;
                hold_cycles = 2000;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= quiet || ($urandom_range(99) >= 34);
        end
    end

    // Checker: every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        exp_beat_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (exp_q.size() == 0)
            begin
                report_mismatch("unexpected beat", res_ch.exponent, '0);
            end
            else
            begin
                want = exp_q.pop_front();
                if (res_ch.exponent !== want.exponent)
                    report_mismatch("exponent", res_ch.exponent, want.exponent);
                if (res_ch.capacity_exceeded !== want.capacity_exceeded)
                    report_mismatch("capacity_exceeded",
                                    WORD_W'(res_ch.capacity_exceeded),
                                    WORD_W'(want.capacity_exceeded));
            end
        end
    end

    // pick a coefficient: small values, extremes or full-range noise
    function automatic logic [WORD_W-1:0] pick_term();
        case ($urandom_range(9))
            0:       return {1'b0, {(WORD_W-1){1'b1}}};
            1:       return {1'b1, {(WORD_W-1){1'b0}}};
            2, 3, 4: return {$urandom, $urandom};
            default: return WORD_W'(longint'($urandom_range(40)) - 20);
        endcase
    endfunction

    initial begin
        dir_row_t  dir_rows [$];
        exp_beat_t te;
        int        rand_cnt;
        int        len;
        int        seq_no;

        fail_cnt  = 0;
        sent_cnt  = 0;
        quiet     = 1'b0;

        // No start after reset: first beat is index 0. Then b_1 passes
        // straight through as a_1. Extremes, negative truncation, restarts.
        dir_rows = '{
            '{64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h0, 1'b0},
            '{64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h7fff_ffff_ffff_ffff, 1'b0},
            '{64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
            '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'h0, 1'b0},
            '{64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
            '{64'h0,                   1'b0, 1'b0, 64'h0, 1'b0},
            '{64'hffff_ffff_ffff_fffb, 1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h0,                   1'b1, 1'b1, 64'h0, 1'b0},
            '{64'h1,                   1'b0, 1'b1, 64'h1, 1'b0},
            '{64'h2,                   1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h3,                   1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h5,                   1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h7,                   1'b0, 1'b0, 64'h0, 1'b0},
            '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'h0, 1'b0},
            '{64'h5555_5555_5555_5555, 1'b1, 1'b1, 64'h0, 1'b0},
            '{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0},
            '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 1'b0}
        };

        @(posedge rst_n);
        @(negedge clk);
        foreach (dir_rows[r])
        begin
            te.exponent          = dir_rows[r].exponent;
            te.capacity_exceeded = dir_rows[r].capacity_exceeded;
            send_beat(dir_rows[r].term, dir_rows[r].start_req, dir_rows[r].typed, te);
        end

        // Random part: mostly restart-led sequences with random content,
        // a few running up to or past capacity, some loose beats that rarely restart.
        rand_cnt = 0;
        seq_no   = 0;
        while (rand_cnt < RAND_BEATS)
        begin
            quiet = (rand_cnt >= 500 && rand_cnt < 700);
            seq_no++;
            if ($urandom_range(99) < 85)
            begin
                len = ($urandom_range(99) < 6 || seq_no == 3) ?
                      $urandom_range(DEPTH - 6, DEPTH + 8) : $urandom_range(1, 24);
                send_beat(pick_term(), 1'b1, 1'b0, te);
                rand_cnt++;
                for (int k = 1; k < len; k++)
                begin
                    send_beat(pick_term(), 1'b0, 1'b0, te);
                    rand_cnt++;
                end
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    send_beat(pick_term(), 1'(($urandom_range(9) == 0)), 1'b0, te);
                    rand_cnt++;
                end
            end
        end
        quiet = 1'b0;
        item_ch.valid <= 1'b0;

        // drain, then allow a longest item's worth of extra cycles
        while (exp_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_cnt == 0 && exp_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

endmodule
